// ===== rtl/core/bllca_pkg.sv =====
// shared constants for the binary lifting lowest common ancestor block
// operation codes, fixed field widths and the node count reset value; no dependencies
package bllca_pkg;

  localparam int OP_W    = 2;
  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int CFG_W   = 11;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;

endpackage

// ===== rtl/core/bllca_ram.sv =====
// generic single write port ram with one registered read port
// used for the node store and the jump table; no dependencies
module bllca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/binary_lifting_lca_top.sv =====
// binary lifting lowest common ancestor: one word at a time through a sequencer
// around two rams (node store, jump table); needs bllca_pkg and bllca_ram
// a query lifts the deeper node level by level, then lifts both nodes together;
//   a build fills level zero from the node store, then each higher level in turn
// throughput: one word at a time, the next word is taken once the sequencer is idle
// reset: synchronous; a clearing pass over all MAX_NODES entries marks every parent absent,
//   no word is taken meanwhile; the jump table reads as absent until built
module binary_lifting_lca_top
  import bllca_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    operation,
  input  logic [NODE_W-1:0]  node_index,
  input  logic [NODE_W-1:0]  parent_node,
  input  logic               is_root,
  input  logic [DEPTH_W-1:0] node_depth,
  input  logic [NODE_W-1:0]  node_a,
  input  logic [NODE_W-1:0]  node_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [NODE_W-1:0]  ancestor
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int NW    = (IDX_W > NODE_W) ? IDX_W : NODE_W;
  localparam int JA_W  = IDX_W + LVL_W;
  localparam int JW    = IDX_W + 1;
  localparam int NRW   = 1 + IDX_W + DEPTH_W;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int PW    = (CNT_W > LEVELS + 1) ? CNT_W : LEVELS + 1;
  localparam int DW1   = DEPTH_W + 1;

  localparam logic [NW:0]    MN1    = (NW + 1)'(MAX_NODES);
  localparam logic [JW-1:0]  ABSENT = {1'b1, {IDX_W{1'b0}}};

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_REDUCE = 5'd2;
  localparam logic [4:0] S_QA     = 5'd3;
  localparam logic [4:0] S_QB     = 5'd4;
  localparam logic [4:0] S_L_CHK  = 5'd5;
  localparam logic [4:0] S_L_JMP  = 5'd6;
  localparam logic [4:0] S_L_DEP  = 5'd7;
  localparam logic [4:0] S_L_END  = 5'd8;
  localparam logic [4:0] S_J_RA   = 5'd9;
  localparam logic [4:0] S_J_RB   = 5'd10;
  localparam logic [4:0] S_J_CMP  = 5'd11;
  localparam logic [4:0] S_FIN_RD = 5'd12;
  localparam logic [4:0] S_FIN    = 5'd13;
  localparam logic [4:0] S_OUT    = 5'd14;
  localparam logic [4:0] S_B0_RD  = 5'd15;
  localparam logic [4:0] S_B0_WR  = 5'd16;
  localparam logic [4:0] S_B_NEXT = 5'd17;
  localparam logic [4:0] S_BJ_RD1 = 5'd18;
  localparam logic [4:0] S_BJ_RD2 = 5'd19;
  localparam logic [4:0] S_BJ_WR  = 5'd20;

  // floor(log2(v)), at least one, capped at the top level
  function automatic logic [3:0] top_level(input logic [DEPTH_W-1:0] v);
    logic [3:0] fl;
    fl = 4'd1;
    for (int i = 2; i < DEPTH_W; i++) begin
      if (v[i]) begin
        fl = 4'(i);
      end
    end
    if (fl > 4'(LEVELS - 1)) begin
      fl = 4'(LEVELS - 1);
    end
    return fl;
  endfunction

  logic [4:0]         state;
  logic [CFG_W-1:0]   node_count;
  logic [CNT_W-1:0]   built_n;
  logic [LVL_W-1:0]   built_top;
  logic [IDX_W-1:0]   clr_idx;

  logic [OP_W-1:0]    r_op;
  logic               r_root;
  logic [DEPTH_W-1:0] r_depth;
  logic [NW-1:0]      r_idx, r_par, r_a, r_b;

  logic [IDX_W-1:0]   p, q, ja, res;
  logic [DEPTH_W-1:0] dp, dq, da;
  logic [LVL_W-1:0]   lvl, lgr;
  logic [CNT_W-1:0]   cnt;
  logic               jv_a, jv_b, ja_ok, b_ok;

  logic               n_we, j_we;
  logic [IDX_W-1:0]   n_waddr, n_raddr;
  logic [NRW-1:0]     n_wdata, n_rdata;
  logic [JA_W-1:0]    j_waddr, j_raddr;
  logic [JW-1:0]      j_wdata, j_rdata;

  logic               n_rd_absent, j_rd_absent;
  logic [IDX_W-1:0]   n_rd_parent, j_rd_val;
  logic [DEPTH_W-1:0] n_rd_depth;

  logic               red_done;
  logic [CNT_W-1:0]   n_eff;
  logic [CMP_W-1:0]   nc_w;
  logic [LVL_W-1:0]   lvl_m1;
  logic [LVL_W:0]     nj;
  logic               more_lvl;
  logic               lift_ok;
  logic               p_valid, q_valid;
  logic               swap;
  logic [DEPTH_W-1:0] dsel;
  logic [3:0]         lg_v;

  assign n_rd_absent = n_rdata[NRW-1];
  assign n_rd_parent = n_rdata[NRW-2 -: IDX_W];
  assign n_rd_depth  = n_rdata[DEPTH_W-1:0];
  assign j_rd_absent = j_rdata[JW-1];
  assign j_rd_val    = j_rdata[IDX_W-1:0];

  assign red_done = ({1'b0, r_idx} < MN1) && ({1'b0, r_par} < MN1) &&
                    ({1'b0, r_a} < MN1) && ({1'b0, r_b} < MN1);

  assign nc_w  = CMP_W'(node_count);
  assign n_eff = (nc_w > CMP_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(node_count);

  assign lvl_m1   = lvl - 1'b1;
  assign nj       = (LVL_W + 1)'(lvl) + 1'b1;
  assign more_lvl = (nj < (LVL_W + 1)'(LEVELS)) && ((PW'(1) << nj) < PW'(built_n));

  assign lift_ok = ({1'b0, dp} >= ({1'b0, dq} + (DW1'(1) << lvl)));

  // entries beyond the last build are absent
  assign p_valid = (CNT_W'(p) < built_n) && (lvl <= built_top);
  assign q_valid = (CNT_W'(q) < built_n) && (lvl <= built_top);

  assign swap = (da < n_rd_depth);
  assign dsel = swap ? n_rd_depth : da;
  assign lg_v = top_level(dsel);

  assign in_stall = (state != S_IDLE);

  always_comb begin
    n_we    = 1'b0;
    n_waddr = clr_idx;
    n_wdata = {1'b1, {IDX_W{1'b0}}, {DEPTH_W{1'b0}}};
    n_raddr = r_a[IDX_W-1:0];
    j_we    = 1'b0;
    j_waddr = {cnt[IDX_W-1:0], lvl};
    j_wdata = ABSENT;
    j_raddr = {p, lvl};
    case (state)
      S_CLEAR: begin
        n_we = 1'b1;
      end
      S_REDUCE: begin
        if (red_done && r_op == OP_LOAD) begin
          n_we    = 1'b1;
          n_waddr = r_idx[IDX_W-1:0];
          n_wdata = {r_root, r_par[IDX_W-1:0], r_depth};
        end
      end
      S_QA:     n_raddr = r_b[IDX_W-1:0];
      S_L_JMP:  n_raddr = j_rd_val;
      S_J_RB:   j_raddr = {q, lvl};
      S_FIN_RD: n_raddr = p;
      S_B0_RD:  n_raddr = cnt[IDX_W-1:0];
      S_B0_WR: begin
        j_we    = 1'b1;
        j_waddr = {cnt[IDX_W-1:0], {LVL_W{1'b0}}};
        j_wdata = {n_rd_absent, n_rd_parent};
      end
      S_BJ_RD1: j_raddr = {cnt[IDX_W-1:0], lvl_m1};
      S_BJ_RD2: j_raddr = {j_rd_val, lvl_m1};
      S_BJ_WR: begin
        j_we    = 1'b1;
        j_wdata = b_ok ? j_rdata : ABSENT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      node_count <= NODE_COUNT_RST;
      built_n    <= '0;
      built_top  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        node_count <= cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(MAX_NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            r_op    <= operation;
            r_root  <= is_root;
            r_depth <= node_depth;
            r_idx   <= NW'(node_index);
            r_par   <= NW'(parent_node);
            r_a     <= NW'(node_a);
            r_b     <= NW'(node_b);
            state   <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (!red_done) begin
            // node numbers wrap at MAX_NODES
            if ({1'b0, r_idx} >= MN1) r_idx <= NW'({1'b0, r_idx} - MN1);
            if ({1'b0, r_par} >= MN1) r_par <= NW'({1'b0, r_par} - MN1);
            if ({1'b0, r_a} >= MN1)   r_a   <= NW'({1'b0, r_a} - MN1);
            if ({1'b0, r_b} >= MN1)   r_b   <= NW'({1'b0, r_b} - MN1);
          end else begin
            unique case (r_op)
              OP_BUILD: begin
                built_n   <= n_eff;
                built_top <= '0;
                lvl       <= '0;
                cnt       <= '0;
                state     <= S_B0_RD;
              end
              OP_QUERY: state <= S_QA;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_QA: begin
          da    <= n_rd_depth;
          state <= S_QB;
        end
        S_QB: begin
          // deeper node goes to p
          if (swap) begin
            p  <= r_b[IDX_W-1:0];
            dp <= n_rd_depth;
            q  <= r_a[IDX_W-1:0];
            dq <= da;
          end else begin
            p  <= r_a[IDX_W-1:0];
            dp <= da;
            q  <= r_b[IDX_W-1:0];
            dq <= n_rd_depth;
          end
          lvl   <= LVL_W'(lg_v);
          lgr   <= LVL_W'(lg_v);
          state <= S_L_CHK;
        end
        S_L_CHK: begin
          if (lift_ok) begin
            jv_a  <= p_valid;
            state <= S_L_JMP;
          end else if (lvl == '0) begin
            state <= S_L_END;
          end else begin
            lvl <= lvl_m1;
          end
        end
        S_L_JMP: begin
          if (jv_a && !j_rd_absent) begin
            p     <= j_rd_val;
            state <= S_L_DEP;
          end else if (lvl == '0) begin
            state <= S_L_END;
          end else begin
            lvl   <= lvl_m1;
            state <= S_L_CHK;
          end
        end
        S_L_DEP: begin
          dp <= n_rd_depth;
          if (lvl == '0) begin
            state <= S_L_END;
          end else begin
            lvl   <= lvl_m1;
            state <= S_L_CHK;
          end
        end
        S_L_END: begin
          if (p == q) begin
            res   <= p;
            state <= S_OUT;
          end else begin
            lvl   <= lgr;
            state <= S_J_RA;
          end
        end
        S_J_RA: begin
          jv_a  <= p_valid;
          state <= S_J_RB;
        end
        S_J_RB: begin
          ja    <= j_rd_val;
          ja_ok <= jv_a && !j_rd_absent;
          jv_b  <= q_valid;
          state <= S_J_CMP;
        end
        S_J_CMP: begin
          // both move only when both ancestors exist and differ
          if (ja_ok && jv_b && !j_rd_absent && ja != j_rd_val) begin
            p <= ja;
            q <= j_rd_val;
          end
          if (lvl == '0) begin
            state <= S_FIN_RD;
          end else begin
            lvl   <= lvl_m1;
            state <= S_J_RA;
          end
        end
        S_FIN_RD: state <= S_FIN;
        S_FIN: begin
          res   <= n_rd_absent ? '0 : n_rd_parent;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            ancestor  <= NODE_W'(NW'(res));
            state     <= S_IDLE;
          end
        end
        S_B0_RD: begin
          state <= (cnt == built_n) ? S_B_NEXT : S_B0_WR;
        end
        S_B0_WR: begin
          cnt   <= cnt + 1'b1;
          state <= S_B0_RD;
        end
        S_B_NEXT: begin
          if (more_lvl) begin
            lvl       <= LVL_W'(nj);
            built_top <= LVL_W'(nj);
            cnt       <= '0;
            state     <= S_BJ_RD1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_BJ_RD1: begin
          state <= (cnt == built_n) ? S_B_NEXT : S_BJ_RD2;
        end
        S_BJ_RD2: begin
          // ancestors outside the built range count as absent
          b_ok  <= !j_rd_absent && (CNT_W'(j_rd_val) < built_n);
          state <= S_BJ_WR;
        end
        S_BJ_WR: begin
          cnt   <= cnt + 1'b1;
          state <= S_BJ_RD1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bllca_ram #(
    .WIDTH(NRW),
    .DEPTH(MAX_NODES)
  ) u_node_ram (
    .clk  (clk),
    .we   (n_we),
    .waddr(n_waddr),
    .wdata(n_wdata),
    .raddr(n_raddr),
    .rdata(n_rdata)
  );

  bllca_ram #(
    .WIDTH(JW),
    .DEPTH(2 ** JA_W)
  ) u_jump_ram (
    .clk  (clk),
    .we   (j_we),
    .waddr(j_waddr),
    .wdata(j_wdata),
    .raddr(j_raddr),
    .rdata(j_rdata)
  );

endmodule
